### sv/wtg_pkg.sv
// Package for the wave table generator: register indexes, field widths,
// CORDIC angle table and gain. No dependencies.
`timescale 1ns / 1ps

package wtg_pkg;

  // Field widths of the words on the channels
  localparam int INDEX_W = 16;
  localparam int VALUE_W = 32;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_WAVE_KIND    = 3'd0,
    REG_TABLE_LENGTH = 3'd1,
    REG_INDEX_SHIFT  = 3'd2,
    REG_LOW_VALUE    = 3'd3,
    REG_HIGH_VALUE   = 3'd4
  } reg_idx_t;

  // CORDIC: 30 rotation steps, angles in binary units (2^32 per turn)
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] CORDIC_ANGLE [0:CORDIC_STEPS-1] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  // Quarter (CORDIC) and unit-value clamp, Q1.30
  localparam logic signed [34:0] UNIT_Q30 = 35'sd1073741824;

endpackage

### sv/wtg_if.sv
// Stream interfaces of the wave table generator: index words in, samples out.
// Depends on wtg_pkg for the field widths.
`timescale 1ns / 1ps

interface wtg_index_if;
  logic                          valid;
  logic                          ready;
  logic [wtg_pkg::INDEX_W-1:0]   entry_index;
  modport source (output valid, output entry_index, input ready);
  modport sink   (input valid, input entry_index, output ready);
endinterface

interface wtg_wave_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wtg_pkg::VALUE_W-1:0]   wave_value;
  modport source (output valid, output wave_value, input ready);
  modport sink   (input valid, input wave_value, output ready);
endinterface

### sv/wave_table_generator.sv
// Wave table generator top level: APB register file and the sample pipeline.
// Depends on wtg_pkg and the stream interfaces in wtg_if.sv.
//
// Usage:
//   req  carries one table index per word (valid/ready, accepted when both
//        are high). rsp returns one 32-bit signed sample per index, in order.
//   The APB port holds wave_kind, table_length, index_shift, low_value and
//   high_value at byte addresses 0, 4, 8, 12, 16; write them while idle.
//   Throughput: one word per cycle, sustained while rsp does not stall.
//   Pipeline: 17 + FRACTION_BITS + 33 register stages (74 at the defaults):
//   17 restoring steps for the modulo by the length, FRACTION_BITS steps for
//   the fraction divide, 30 CORDIC steps, then shape select, multiply and
//   round/saturate, one register stage each.
//   Reset clears all valid bits and loads the register defaults
//   (sine, length 1024, shift 0, range -32768..32767).
//   When rsp stalls, the whole pipeline holds and req.ready drops; the
//   pipeline resumes with nothing lost or repeated once rsp.ready returns.
`timescale 1ns / 1ps

module wave_table_generator #(
  parameter int INDEX_BITS    = 16,
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  wtg_index_if.sink   req,
  wtg_wave_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wtg_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int LW  = INDEX_BITS + 1;          // length width
  localparam int CW  = (LW > 17) ? LW : 17;     // compare width for the clamp
  localparam int SW  = INDEX_W + 1;             // index + shift
  localparam int NC  = CORDIC_STEPS;
  localparam int XW  = 34;                      // CORDIC x/y width
  localparam int UW  = F + 1;                   // unit value Q1.F
  localparam int PW  = 32 + UW;                 // product width
  localparam logic [UW-1:0] HALF_U  = UW'(1) << (F - 1);
  localparam logic [UW-1:0] THREE_H = HALF_U + HALF_U + HALF_U;
  localparam logic [UW-1:0] ONE_U   = UW'(1) << F;

  // ---------------- configuration registers ----------------
  logic                wave_kind;
  logic [16:0]         table_length;
  logic [15:0]         index_shift;
  logic signed [31:0]  low_value;
  logic signed [31:0]  high_value;

  assign pready = 1'b1;

  // Write a register at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_kind    <= 1'b0;
      table_length <= 17'd1024;
      index_shift  <= 16'd0;
      low_value    <= -32'sd32768;
      high_value   <= 32'sd32767;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_WAVE_KIND:    wave_kind    <= pwdata[0];
        REG_TABLE_LENGTH: table_length <= pwdata[16:0];
        REG_INDEX_SHIFT:  index_shift  <= pwdata[15:0];
        REG_LOW_VALUE:    low_value    <= pwdata;
        REG_HIGH_VALUE:   high_value   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[4:2])
      REG_WAVE_KIND:    prdata = {31'd0, wave_kind};
      REG_TABLE_LENGTH: prdata = {15'd0, table_length};
      REG_INDEX_SHIFT:  prdata = {16'd0, index_shift};
      REG_LOW_VALUE:    prdata = low_value;
      REG_HIGH_VALUE:   prdata = high_value;
      default:          prdata = 32'd0;
    endcase
  end

  // Effective length: zero acts as one, clamp to 2^INDEX_BITS
  logic [CW-1:0] tl_ext;
  logic [LW-1:0] len_eff;
  localparam logic [CW-1:0] LEN_MAX = CW'(1) << INDEX_BITS;
  always_comb begin
    tl_ext = CW'(table_length);
    if (tl_ext == '0)          len_eff = LW'(1);
    else if (tl_ext > LEN_MAX) len_eff = LW'(LEN_MAX);
    else                       len_eff = LW'(tl_ext);
  end

  // Range magnitude and sign for the scaling multiply
  logic signed [32:0] range_s;
  logic [31:0]        range_mag;
  logic               range_neg;
  always_comb begin
    range_s   = 33'(high_value) - 33'(low_value);
    range_neg = range_s[32];
    range_mag = range_neg ? 32'(-range_s) : 32'(range_s);
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic out_v;
  logic signed [31:0] out_val;

  // Advance every stage unless the result word is held
  assign en        = !out_v || rsp.ready;
  assign req.ready = en;

  logic [SW-1:0] sum_in;
  assign sum_in = SW'(req.entry_index) + SW'(index_shift);

  // ---------------- modulo by length: one restoring step per stage ----------
  logic          m_v   [0:SW-1];
  logic [LW-1:0] m_rem [0:SW-1];
  logic [SW-1:0] m_sum [0:SW-1];

  for (genvar k = 0; k < SW; k++) begin : g_mod
    logic          pv;
    logic [LW-1:0] prem;
    logic [SW-1:0] psum;
    logic [LW:0]   t;
    logic          ge;
    if (k == 0) begin : g_first
      assign pv   = req.valid;
      assign prem = '0;
      assign psum = sum_in;
    end else begin : g_next
      assign pv   = m_v[k-1];
      assign prem = m_rem[k-1];
      assign psum = m_sum[k-1];
    end
    assign t  = {prem, psum[SW-1-k]};
    assign ge = t >= {1'b0, len_eff};

    always_ff @(posedge clk) begin
      if (rst) begin
        m_v[k] <= 1'b0;
      end else if (en) begin
        m_v[k] <= pv;
      end
    end

    // Shift in the next sum bit, subtract the length when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        m_rem[k] <= ge ? LW'(t - {1'b0, len_eff}) : LW'(t);
        m_sum[k] <= psum;
      end
    end
  end

  // ---------------- fraction point*2^F/len: one quotient bit per stage -------
  logic          d_v   [0:F-1];
  logic [LW-1:0] d_rem [0:F-1];
  logic [F-1:0]  d_q   [0:F-1];

  for (genvar k = 0; k < F; k++) begin : g_div
    logic          pv;
    logic [LW-1:0] prem;
    logic [F-1:0]  pq;
    logic [LW:0]   t;
    logic          ge;
    if (k == 0) begin : g_first
      assign pv   = m_v[SW-1];
      assign prem = m_rem[SW-1];
      assign pq   = '0;
    end else begin : g_next
      assign pv   = d_v[k-1];
      assign prem = d_rem[k-1];
      assign pq   = d_q[k-1];
    end
    assign t  = {prem, 1'b0};
    assign ge = t >= {1'b0, len_eff};

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[k] <= 1'b0;
      end else if (en) begin
        d_v[k] <= pv;
      end
    end

    // Double the remainder, take one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[k] <= ge ? LW'(t - {1'b0, len_eff}) : LW'(t);
        d_q[k]   <= {pq[F-2:0], ge};
      end
    end
  end

  // ---------------- CORDIC rotation: one step per stage ----------------
  logic                 c_v [0:NC-1];
  logic signed [XW-1:0] c_x [0:NC-1];
  logic signed [XW-1:0] c_y [0:NC-1];
  logic signed [31:0]   c_z [0:NC-1];
  logic [1:0]           c_q [0:NC-1];
  logic [F-1:0]         c_f [0:NC-1];

  logic [31:0] ang;
  assign ang = 32'(d_q[F-1]) << (32 - F);

  for (genvar k = 0; k < NC; k++) begin : g_cordic
    logic                 pv;
    logic signed [XW-1:0] px;
    logic signed [XW-1:0] py;
    logic signed [31:0]   pz;
    logic [1:0]           pq;
    logic [F-1:0]         pf;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    if (k == 0) begin : g_first
      assign pv = d_v[F-1];
      assign px = XW'(CORDIC_GAIN);
      assign py = '0;
      assign pz = {2'b00, ang[29:0]};
      assign pq = ang[31:30];
      assign pf = d_q[F-1];
    end else begin : g_next
      assign pv = c_v[k-1];
      assign px = c_x[k-1];
      assign py = c_y[k-1];
      assign pz = c_z[k-1];
      assign pq = c_q[k-1];
      assign pf = c_f[k-1];
    end
    assign dx = py >>> k;
    assign dy = px >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[k] <= 1'b0;
      end else if (en) begin
        c_v[k] <= pv;
      end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (!pz[31]) begin
          c_x[k] <= px - dx;
          c_y[k] <= py + dy;
          c_z[k] <= pz - CORDIC_ANGLE[k];
        end else begin
          c_x[k] <= px + dx;
          c_y[k] <= py - dy;
          c_z[k] <= pz + CORDIC_ANGLE[k];
        end
        c_q[k] <= pq;
        c_f[k] <= pf;
      end
    end
  end

  // ---------------- shape select: unit value Q1.F ----------------
  logic signed [34:0] s_raw;
  logic signed [34:0] s_clamp;
  logic [32:0]        u32;
  logic [UW-1:0]      u_sine;
  logic [UW-1:0]      u_tri;
  logic [UW-1:0]      tri_d;
  logic [F-1:0]       fin;
  logic               sel_v;
  logic [UW-1:0]      sel_u;

  // Unfold the quarter and clamp to [-1, 1]
  always_comb begin
    case (c_q[NC-1])
      2'd0:    s_raw = 35'(c_y[NC-1]);
      2'd1:    s_raw = 35'(c_x[NC-1]);
      2'd2:    s_raw = -35'(c_y[NC-1]);
      default: s_raw = -35'(c_x[NC-1]);
    endcase
    if (s_raw > UNIT_Q30)       s_clamp = UNIT_Q30;
    else if (s_raw < -UNIT_Q30) s_clamp = -UNIT_Q30;
    else                        s_clamp = s_raw;
    u32 = {32'(s_clamp + UNIT_Q30), 1'b0};
  end

  // Round Q1.32 half up to Q1.F
  if (F < 32) begin : g_round
    logic [32:0] u_rnd;
    assign u_rnd  = u32 + (33'd1 << (31 - F));
    assign u_sine = UW'(u_rnd >> (32 - F));
  end else begin : g_exact
    assign u_sine = UW'(u32);
  end

  // Triangle: four linear pieces, starting at one half
  always_comb begin
    fin   = c_f[NC-1];
    tri_d = {fin, 1'b0};
    case (fin[F-1:F-2])
      2'd0:    u_tri = tri_d + HALF_U;
      2'd3:    u_tri = tri_d - THREE_H;
      default: u_tri = THREE_H - tri_d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_v <= 1'b0;
    end else if (en) begin
      sel_v <= c_v[NC-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_u <= wave_kind ? u_tri : u_sine;
    end
  end

  // ---------------- scale: |range| * u ----------------
  logic          mul_v;
  logic [PW-1:0] mul_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else if (en) begin
      mul_v <= sel_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_p <= PW'(range_mag) * PW'(sel_u);
    end
  end

  // ---------------- add low, round half away from zero, saturate ----------
  logic [32:0]        ip;
  logic [F-1:0]       fp;
  logic [UW-1:0]      fr;
  logic signed [34:0] whole;
  logic signed [34:0] res;
  logic               up;
  logic signed [31:0] res_sat;

  always_comb begin
    ip = mul_p[PW-1:F];
    fp = mul_p[F-1:0];
    if (range_neg && fp != '0) begin
      whole = 35'(low_value) - 35'(ip) - 35'sd1;
      fr    = ONE_U - UW'(fp);
    end else if (range_neg) begin
      whole = 35'(low_value) - 35'(ip);
      fr    = UW'(fp);
    end else begin
      whole = 35'(low_value) + 35'(ip);
      fr    = UW'(fp);
    end
    up  = (fr > HALF_U) || (fr == HALF_U && !whole[34]);
    res = whole + 35'(up);
    if (res > 35'sd2147483647)       res_sat = 32'sh7fffffff;
    else if (res < -35'sd2147483648) res_sat = 32'sh80000000;
    else                             res_sat = 32'(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= mul_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val <= res_sat;
    end
  end

  assign rsp.valid      = out_v;
  assign rsp.wave_value = out_val;

  // ---------------- assertions ----------------
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    req.valid && en |=> m_v[0])
    else $error("accepted word did not enter the pipeline");

  a_mod_below_len: assert property (@(posedge clk) disable iff (rst)
    m_v[SW-1] |-> m_rem[SW-1] < len_eff)
    else $error("modulo result not below the table length");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    d_v[F-1] |-> d_rem[F-1] < len_eff)
    else $error("fraction divide remainder out of range");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    sel_v |-> sel_u <= ONE_U)
    else $error("unit value above one");

endmodule

### verif/wave_table_generator_tb.sv
// Testbench for wave_table_generator: drives table indexes under several
// register settings and idling mixes, checks every sample against a predictor.
// Depends on wtg_pkg, the stream interfaces in wtg_if.sv and the top level.
`timescale 1ns / 1ps

module wave_table_generator_tb;
  import wtg_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int FRAC = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wtg_index_if req_if ();
  wtg_wave_if  rsp_if ();

  wave_table_generator u_top (
    .clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Register mirror
  logic        cfg_kind;
  logic [16:0] cfg_len;
  logic [15:0] cfg_shift;
  logic signed [31:0] cfg_lo, cfg_hi;

  logic signed [31:0] wave_expect_q[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  initial begin
    req_if.valid = 1'b0;
    req_if.entry_index = '0;
    rsp_if.ready = 1'b0;
  end

  // Sine unit value (Q1.F) by a 30-step rotation CORDIC
  function automatic longint sine_unit(longint f);
    longint a, z, x, y, dx, dy, s, u32;
    int q;
    a = (f << (32 - FRAC)) & 64'hFFFF_FFFF;
    q = int'(a >> 30);
    z = a & 64'h3FFF_FFFF;
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(CORDIC_ANGLE[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(CORDIC_ANGLE[i]);
      end
    end
    case (q)
      0: s = y;
      1: s = x;
      2: s = -y;
      default: s = -x;
    endcase
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (s < -64'sd1073741824) s = -64'sd1073741824;
    u32 = (s + 64'sd1073741824) << 1;
    return (u32 + (64'sd1 << (31 - FRAC))) >> (32 - FRAC);
  endfunction

  // Triangle unit value (Q1.F), starting at one half
  function automatic longint triangle_unit(longint f);
    longint half, d, u;
    int q;
    half = 64'sd1 << (FRAC - 1);
    d = f << 1;
    q = int'((f >> (FRAC - 2)) & 3);
    if (q == 0) u = d + half;
    else if (q == 3) u = d - 3 * half;
    else u = 3 * half - d;
    if (u < 0) u = 0;
    return u;
  endfunction

  // Expected sample for one index under the current registers
  function automatic logic signed [31:0] wave_sample(logic [15:0] idx);
    longint len, point, f, u, range, mag, ip, fp, whole, res, fmask, half;
    len = cfg_len;
    if (len == 0) len = 1;
    if (len > 65536) len = 65536;
    point = (longint'(idx) + longint'(cfg_shift)) % len;
    f = (point << FRAC) / len;
    u = cfg_kind ? triangle_unit(f) : sine_unit(f);
    range = longint'(cfg_hi) - longint'(cfg_lo);
    mag = (range < 0) ? -range : range;
    mag = mag * u;
    fmask = (64'sd1 << FRAC) - 1;
    ip = mag >> FRAC;
    fp = mag & fmask;
    if (range < 0 && fp != 0) begin
      whole = longint'(cfg_lo) - ip - 1;
      fp = fmask + 1 - fp;
    end else if (range < 0) begin
      whole = longint'(cfg_lo) - ip;
    end else begin
      whole = longint'(cfg_lo) + ip;
    end
    half = 64'sd1 << (FRAC - 1);
    res = whole;
    if (fp > half || (fp == half && whole >= 0)) res = whole + 1;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // Receiver stalls
  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each returned word with the oldest expected sample
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (wave_expect_q.size() == 0) begin
        $error("wave_value: unexpected word, actual %0d", rsp_if.wave_value);
        errors++;
      end else begin
        logic signed [31:0] want;
        want = wave_expect_q.pop_front();
        if (rsp_if.wave_value !== want) begin
          $error("wave_value: expected %0d, actual %0d", want, rsp_if.wave_value);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Register write over APB, mirrored into the predictor's copy
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WAVE_KIND:    cfg_kind = value[0];
      REG_TABLE_LENGTH: cfg_len = value[16:0];
      REG_INDEX_SHIFT:  cfg_shift = value[15:0];
      REG_LOW_VALUE:    cfg_lo = value;
      REG_HIGH_VALUE:   cfg_hi = value;
      default: ;
    endcase
    // Hold the bus idle between transfers
    @(posedge clk);
  endtask

  // Send one index word, with random idling ahead of it
  task automatic send_index(logic [15:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.entry_index <= idx;
    do @(posedge clk); while (!req_if.ready);
    wave_expect_q.push_back(wave_sample(idx));
  endtask

  // Drop valid and wait until all samples are back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (wave_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic kind, logic [31:0] len, logic [15:0] shift,
                            logic [31:0] lo, logic [31:0] hi);
    reg_write(REG_WAVE_KIND, {31'd0, kind});
    reg_write(REG_TABLE_LENGTH, len);
    reg_write(REG_INDEX_SHIFT, {16'd0, shift});
    reg_write(REG_LOW_VALUE, lo);
    reg_write(REG_HIGH_VALUE, hi);
  endtask

  // Reset defaults: sine over 1024 entries, quarter points and wrap
  task automatic test_defaults();
    logic [15:0] pts[10] = '{16'd0, 16'd1, 16'd255, 16'd256, 16'd511, 16'd512,
                             16'd767, 16'd768, 16'd1023, 16'hFFFF};
    foreach (pts[i]) send_index(pts[i]);
    drain();
  endtask

  // Triangle, full-scale and inverted ranges, odd lengths, unused address
  task automatic test_edges();
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    set_config(1'b1, 32'd1024, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_index(16'd0); send_index(16'd256); send_index(16'd512);
    send_index(16'd768); send_index(16'd1023);
    drain();
    set_config(1'b0, 32'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_index(16'hFFFF); send_index(16'd0);
    drain();
    set_config(1'b1, 32'd65536, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_index(16'd0); send_index(16'h8000); send_index(16'hFFFF);
    drain();
    set_config(1'b0, 32'h1_FFFF, 16'h1234, 32'd1000, 32'd1000);
    send_index(16'hAAAA); send_index(16'h5555);
    drain();
    set_config(1'b1, 32'd3, 16'd7, -32'sd5, 32'sd4);
    send_index(16'd0); send_index(16'd1); send_index(16'd2);
    drain();
  endtask

  // Random registers and indexes under one idling mix
  task automatic test_random(int idle, int stall, int count);
    logic [31:0] len, lo, hi;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n += 50) begin
      case ($urandom_range(3))
        0: len = $urandom_range(1, 16);
        1: len = $urandom_range(1, 65536);
        2: len = $urandom_range(0, 131071);
        default: len = ($urandom_range(1) != 0) ? 32'd65536 : 32'd1;
      endcase
      case ($urandom_range(2))
        0: begin lo = $urandom; hi = $urandom; end
        1: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        default: begin
          lo = $urandom_range(0, 2000) - 1000;
          hi = $urandom_range(0, 2000) - 1000;
        end
      endcase
      set_config(1'($urandom_range(1)), len, 16'($urandom), lo, hi);
      for (int k = 0; k < 50; k++) send_index(16'($urandom));
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    cfg_kind = 1'b0;
    cfg_len = 17'd1024;
    cfg_shift = '0;
    cfg_lo = -32'sd32768;
    cfg_hi = 32'sd32767;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_edges();
    test_random(0, 0, 150);
    test_random(76, 0, 150);
    test_random(0, 76, 150);
    test_random(38, 38, 150);

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
